// File: design/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types and constants shared by the I2C master byte sequencer modules.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // Command codes carried by the mode field.
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // Last phase number of each command sequence.
  localparam logic [4:0] LAST_PHASE_SHORT = 5'd2;
  localparam logic [4:0] LAST_PHASE_WRITE = 5'd26;
  localparam logic [4:0] LAST_PHASE_READ  = 5'd20;

  // Bit position shifted out first on a write.
  localparam int unsigned TX_MSB = 7;

  // Sequencer state carried from one phase to the next.
  typedef struct packed {
    logic       running;
    cmd_t       cmd;
    logic [4:0] phase;
    logic [1:0] sub;
    logic [7:0] shift;
    logic       ack_to_send;
    logic       scl;
    logic       sda;
    logic       slave_ack;
    logic [7:0] rx_hold;
  } seq_state_t;

  // State after reset: idle, with both lines released high.
  localparam seq_state_t SEQ_RESET = '{
    running:     1'b0,
    cmd:         CMD_START,
    phase:       5'd0,
    sub:         2'd0,
    shift:       8'd0,
    ack_to_send: 1'b0,
    scl:         1'b1,
    sda:         1'b1,
    slave_ack:   1'b0,
    rx_hold:     8'd0
  };

  // Flags reported for one phase.
  typedef struct packed {
    logic busy;
    logic done;
  } phase_flags_t;

  function automatic logic [4:0] last_phase(input cmd_t cmd);
    logic [4:0] lp;
    case (cmd)
      CMD_WRITE: lp = LAST_PHASE_WRITE;
      CMD_READ:  lp = LAST_PHASE_READ;
      default:   lp = LAST_PHASE_SHORT;
    endcase
    return lp;
  endfunction

endpackage

// File: design/i2c_master_byte_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer
// I2C master pin sequencer advanced by one phase tick per input beat.
// ----------------------------------------------------------------------------
// Each input beat is one delay phase from a prescaler. It may carry a
// command (start, stop, write byte, read byte) and always carries the sampled
// SDA level. A command is taken only while the sequencer is idle; commands
// offered while one is running are dropped. Start and stop take 3 phases,
// a write 27 and a read 21.
// Every input beat yields exactly one output beat with the SCL and SDA levels
// after that phase, the busy flag, the received byte and the last write ACK.
// out_tlast marks the last phase of a command.
// The output beat is registered from the accepted input beat, and a new
// beat can be taken in every cycle while the receiver takes results: the
// step logic sits between the state registers and a single output register.
// When the receiver stalls, the output beat holds and in_tready drops once
// the output register is full, so no phase is lost.
// Reset releases both lines high, clears the state and empties the output.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer
  import i2cms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input phase channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // cmd_valid[0], tx_byte[8:1], send_ack[9],
                                  // sda_in[10], zero fill above
  input  logic [1:0]  in_tuser,   // mode[1:0]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // scl_level[0], sda_level[1], busy_res[2],
                                  // rx_byte[10:3], ack_seen[11], zero fill above
  output logic        out_tlast   // done_res
);

  seq_state_t   state_r;
  seq_state_t   state_nxt;
  phase_flags_t flags;
  logic         out_tvalid_r;
  logic         busy_r;
  logic         done_r;
  logic         in_accept;

  // Output register frees as it drains: a beat every cycle with out_tready high.
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  // One phase of the sequence.
  i2cms_phase u_phase (
    .cur       (state_r),
    .cmd_valid (in_tdata[0]),
    .mode      (cmd_t'(in_tuser)),
    .tx_byte   (in_tdata[8:1]),
    .send_ack  (in_tdata[9]),
    .sda_in    (in_tdata[10]),
    .nxt       (state_nxt),
    .flags     (flags)
  );

  // State advances once per accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_RESET;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // Output register and its valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      busy_r       <= 1'b0;
      done_r       <= 1'b0;
    end else if (in_accept) begin
      out_tvalid_r <= 1'b1;
      busy_r       <= flags.busy;
      done_r       <= flags.done;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  // The pin levels, received byte and ACK are the registered state itself.
  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = done_r;
  assign out_tdata  = {4'b0000, state_r.slave_ack, state_r.rx_hold, busy_r,
                       state_r.sda, state_r.scl};

endmodule

// File: design/i2cms_phase.sv
// ----------------------------------------------------------------------------
// i2cms_phase
// Combinational step of the sequencer: takes the current state and one phase
// beat and produces the state after that phase, with busy and done flags.
// ----------------------------------------------------------------------------
module i2cms_phase
  import i2cms_pkg::*;
(
  input  seq_state_t   cur,
  input  logic         cmd_valid,
  input  cmd_t         mode,
  input  logic [7:0]   tx_byte,
  input  logic         send_ack,
  input  logic         sda_in,
  output seq_state_t   nxt,
  output phase_flags_t flags
);

  // Sub-phase of one written bit: set up data, raise SCL, lower SCL.
  localparam logic [1:0] BIT_SETUP = 2'd0;
  localparam logic [1:0] BIT_HIGH  = 2'd1;
  localparam logic [1:0] BIT_LOW   = 2'd2;

  // Phase numbers of the tail of write and read sequences.
  localparam logic [4:0] WR_BITS_END = 5'd24;
  localparam logic [4:0] WR_ACK_REL  = 5'd24;
  localparam logic [4:0] WR_ACK_HIGH = 5'd25;
  localparam logic [4:0] RD_BITS_END = 5'd16;
  localparam logic [4:0] RD_GAP      = 5'd16;
  localparam logic [4:0] RD_ACK_SET  = 5'd17;
  localparam logic [4:0] RD_ACK_HIGH = 5'd18;
  localparam logic [4:0] RD_ACK_LOW  = 5'd19;

  seq_state_t s;

  always_comb begin
    s = cur;
    flags = '0;

    // A command is taken only while idle; its first phase runs at once.
    if (!s.running && cmd_valid) begin
      s.running     = 1'b1;
      s.cmd         = mode;
      s.phase       = '0;
      s.sub         = BIT_SETUP;
      s.shift       = (mode == CMD_WRITE) ? tx_byte : '0;
      s.ack_to_send = send_ack;
    end

    if (s.running) begin
      flags.busy = 1'b1;

      // Pin action for this phase.
      case (s.cmd)
        CMD_START: begin
          if (s.phase == 5'd0) s.scl = 1'b1;
          else if (s.phase == 5'd1) s.sda = 1'b0;
          else s.scl = 1'b0;
        end
        CMD_STOP: begin
          if (s.phase == 5'd0) s.sda = 1'b0;
          else if (s.phase == 5'd1) s.scl = 1'b1;
          else s.sda = 1'b1;
        end
        CMD_WRITE: begin
          if (s.phase < WR_BITS_END) begin
            case (s.sub)
              BIT_SETUP: s.sda = s.shift[TX_MSB];
              BIT_HIGH:  s.scl = 1'b1;
              default: begin
                s.scl   = 1'b0;
                s.shift = {s.shift[TX_MSB-1:0], 1'b0};
              end
            endcase
          end else if (s.phase == WR_ACK_REL) begin
            s.sda = 1'b1;
          end else if (s.phase == WR_ACK_HIGH) begin
            s.scl       = 1'b1;
            s.slave_ack = !sda_in;
          end else begin
            s.scl = 1'b0;
          end
        end
        default: begin
          if (s.phase < RD_BITS_END) begin
            if (!s.phase[0]) begin
              s.scl   = 1'b1;
              s.shift = {s.shift[TX_MSB-1:0], sda_in};
            end else begin
              s.scl = 1'b0;
            end
          end else if (s.phase == RD_GAP) begin
            s.scl = 1'b0;
          end else if (s.phase == RD_ACK_SET) begin
            s.sda = !s.ack_to_send;
          end else if (s.phase == RD_ACK_HIGH) begin
            s.scl = 1'b1;
          end else if (s.phase == RD_ACK_LOW) begin
            s.scl = 1'b0;
          end else begin
            s.sda     = 1'b1;
            s.rx_hold = s.shift;
          end
        end
      endcase

      // Advance the phase counter, or finish on the last phase.
      if (s.phase >= last_phase(s.cmd)) begin
        flags.done = 1'b1;
        s.running  = 1'b0;
        s.phase    = '0;
      end else begin
        s.phase = s.phase + 5'd1;
      end
      s.sub = (s.sub == BIT_LOW) ? BIT_SETUP : s.sub + 2'd1;
    end

    nxt = s;
  end

endmodule

// File: design/i2cms_checker.sv
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks for the I2C master byte sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module i2cms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // A command's last phase is always a busy phase.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[2])
    else $error("done without busy");

  // The output is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // With the output register empty the block takes input.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("not ready with empty output");

  // A stalled result beat holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast))
    else $error("stalled result changed");

  // The fill bits of the result are zero.
  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:12] == 4'b0000)
    else $error("fill bits set");

endmodule

bind i2c_master_byte_sequencer i2cms_checker u_i2cms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C master byte sequencer.
// ----------------------------------------------------------------------------
// Every input beat is one phase tick. The bench sends directed start, stop,
// write and read commands first, then random bus transactions framed by start
// and stop, mixed with raw noise beats. Commands are offered during running
// sequences as well. A scoreboard class keeps its own copy of the sequencer
// state and predicts the pin levels and flags of every phase. Each output
// beat is compared field by field with the oldest prediction. The sender
// works in bursts with random gaps, and the receiver stalls in changing
// styles.
// ----------------------------------------------------------------------------
module tb;
  import i2cms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TOTAL_BEATS = 1450;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Fields of one output beat.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } pin_levels_t;

  // Phase predictor and store of expected pin levels.
  class i2c_phase_scoreboard;
    pin_levels_t expected_levels[$];
    int unsigned mismatches;
    bit          running;
    cmd_t        cmd;
    logic [4:0]  phase;
    logic [7:0]  shift;
    logic        ack_to_send;
    logic        scl;
    logic        sda;
    logic        slave_ack;
    logic [7:0]  rx_hold;

    function new();
      mismatches  = 0;
      running     = 1'b0;
      cmd         = CMD_START;
      phase       = '0;
      shift       = '0;
      ack_to_send = 1'b0;
      scl         = 1'b1;
      sda         = 1'b1;
      slave_ack   = 1'b0;
      rx_hold     = '0;
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    function bit in_command();
      return running;
    endfunction

    // Advance the model by one accepted phase beat and queue its levels.
    function void note_phase(bit valid, cmd_t mode, logic [7:0] tx, bit ack, bit sda_in);
      pin_levels_t lv;
      logic [4:0]  final_phase;
      lv.busy = 1'b0;
      lv.done = 1'b0;
      if (!running && valid) begin
        running     = 1'b1;
        cmd         = mode;
        phase       = '0;
        shift       = (mode == CMD_WRITE) ? tx : 8'd0;
        ack_to_send = ack;
      end
      if (running) begin
        lv.busy = 1'b1;
        case (cmd)
          CMD_START: begin
            if (phase == 0) scl = 1'b1;
            else if (phase == 1) sda = 1'b0;
            else scl = 1'b0;
          end
          CMD_STOP: begin
            if (phase == 0) sda = 1'b0;
            else if (phase == 1) scl = 1'b1;
            else sda = 1'b1;
          end
          CMD_WRITE: begin
            if (phase < 24) begin
              case (phase % 3)
                0: sda = shift[TX_MSB];
                1: scl = 1'b1;
                default: begin
                  scl   = 1'b0;
                  shift = {shift[6:0], 1'b0};
                end
              endcase
            end else if (phase == 24) begin
              sda = 1'b1;
            end else if (phase == 25) begin
              scl       = 1'b1;
              slave_ack = !sda_in;
            end else begin
              scl = 1'b0;
            end
          end
          default: begin
            // Read: even phases of the first sixteen sample the line.
            if (phase < 16) begin
              if (!phase[0]) begin
                scl   = 1'b1;
                shift = {shift[6:0], sda_in};
              end else begin
                scl = 1'b0;
              end
            end else if (phase == 16) begin
              scl = 1'b0;
            end else if (phase == 17) begin
              sda = !ack_to_send;
            end else if (phase == 18) begin
              scl = 1'b1;
            end else if (phase == 19) begin
              scl = 1'b0;
            end else begin
              sda     = 1'b1;
              rx_hold = shift;
            end
          end
        endcase
        case (cmd)
          CMD_WRITE: final_phase = LAST_PHASE_WRITE;
          CMD_READ:  final_phase = LAST_PHASE_READ;
          default:   final_phase = LAST_PHASE_SHORT;
        endcase
        if (phase >= final_phase) begin
          lv.done = 1'b1;
          running = 1'b0;
          phase   = '0;
        end else begin
          phase = phase + 5'd1;
        end
      end
      lv.scl      = scl;
      lv.sda      = sda;
      lv.rx_byte  = rx_hold;
      lv.ack_seen = slave_ack;
      expected_levels.push_back(lv);
    endfunction

    // Compare one output beat with the oldest prediction.
    function void check_levels(pin_levels_t got);
      pin_levels_t want;
      if (expected_levels.size() == 0) begin
        $display("%0t: output beat with no prediction waiting, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_levels.pop_front();
      if (got.scl !== want.scl) begin
        $display("%0t: scl_level expected %0d actual %0d", $time, want.scl, got.scl);
        mismatches++;
      end
      if (got.sda !== want.sda) begin
        $display("%0t: sda_level expected %0d actual %0d", $time, want.sda, got.sda);
        mismatches++;
      end
      if (got.busy !== want.busy) begin
        $display("%0t: busy_res expected %0d actual %0d", $time, want.busy, got.busy);
        mismatches++;
      end
      if (got.done !== want.done) begin
        $display("%0t: done_res expected %0d actual %0d", $time, want.done, got.done);
        mismatches++;
      end
      if (got.rx_byte !== want.rx_byte) begin
        $display("%0t: rx_byte expected %h actual %h", $time, want.rx_byte, got.rx_byte);
        mismatches++;
      end
      if (got.ack_seen !== want.ack_seen) begin
        $display("%0t: ack_seen expected %0d actual %0d", $time, want.ack_seen,
                 got.ack_seen);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;

  i2c_phase_scoreboard sb = new();
  int unsigned         burst_left = 0;
  int unsigned         beats_sent = 0;
  int unsigned         cycle_count = 0;
  int unsigned         rx_cycle = 0;
  int unsigned         rx_style = 0;

  i2c_master_byte_sequencer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("i2c_master_byte_sequencer test failed");
      $finish;
    end
  end

  // Receiver: the stall style is redrawn at random among four, and output
  // beats are checked as they are taken.
  always @(posedge clk) begin
    pin_levels_t got;
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_style = $urandom_range(0, 3);
    if (rst_n && out_tvalid && out_tready) begin
      got.scl      = out_tdata[0];
      got.sda      = out_tdata[1];
      got.busy     = out_tdata[2];
      got.rx_byte  = out_tdata[10:3];
      got.ack_seen = out_tdata[11];
      got.done     = out_tlast;
      sb.check_levels(got);
    end
    case (rx_style)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 1) == 1);
      2:       out_tready <= (rx_cycle % 4 == 0);
      default: out_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Send one phase beat, opening a new burst after a random gap when the
  // current one is used up.
  task automatic send_beat(bit valid, cmd_t mode, logic [7:0] tx, bit ack, bit sda_in);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 30);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, sda_in, ack, tx, valid};
    in_tuser  <= mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_phase(valid, mode, tx, ack, sda_in);
    burst_left--;
    beats_sent++;
  endtask

  // Phase beats with no command and random content in the other fields.
  task automatic send_idle(int unsigned n);
    repeat (n) send_beat(1'b0, cmd_t'($urandom_range(0, 3)), 8'($urandom),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Drive one whole command. Read bits are taken from rx_bits MSB first and
  // the write ACK phase sees nack. A noisy command offers further commands
  // on the beats after its first one.
  task automatic run_command(cmd_t mode, logic [7:0] tx, bit ack, logic [7:0] rx_bits,
                             bit nack, bit noisy);
    int  n;
    bit  sda_in;
    bit  extra;
    n = (mode == CMD_WRITE) ? int'(LAST_PHASE_WRITE) + 1 :
        (mode == CMD_READ)  ? int'(LAST_PHASE_READ) + 1 : int'(LAST_PHASE_SHORT) + 1;
    for (int p = 0; p < n; p++) begin
      sda_in = 1'($urandom_range(0, 1));
      if (mode == CMD_READ && p < 16 && p % 2 == 0) sda_in = rx_bits[7 - p / 2];
      if (mode == CMD_WRITE && p == 25) sda_in = nack;
      if (p == 0) begin
        send_beat(1'b1, mode, tx, ack, sda_in);
      end else begin
        extra = noisy && ($urandom_range(0, 1) == 1);
        send_beat(extra, cmd_t'($urandom_range(0, 3)), 8'($urandom),
                  1'($urandom_range(0, 1)), sda_in);
      end
    end
  endtask

  // Hold off the sender until every predicted beat has come back.
  task automatic drain_outputs();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned target;
    int unsigned n_bytes;
    bit          drained;
    drained = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every command at the extremes of its fields.
    send_idle(2);
    run_command(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    run_command(CMD_WRITE, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0);
    run_command(CMD_WRITE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0);
    // Commands offered while one is running must be dropped.
    run_command(CMD_WRITE, 8'hA5, 1'b0, 8'h00, 1'b0, 1'b1);
    run_command(CMD_READ, 8'hFF, 1'b1, 8'hFF, 1'b0, 1'b0);
    run_command(CMD_READ, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    run_command(CMD_READ, 8'h3C, 1'b1, 8'h5A, 1'b0, 1'b1);
    run_command(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    send_idle(2);
    run_command(CMD_STOP, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b1);
    run_command(CMD_START, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b1);
    drain_outputs();

    // Random part: mostly framed transactions, some raw noise beats.
    target = TOTAL_BEATS;
    while (beats_sent < target) begin
      if (!drained && beats_sent > target - TOTAL_BEATS / 2) begin
        drain_outputs();
        drained = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 10))
          send_beat(1'($urandom_range(0, 1)), cmd_t'($urandom_range(0, 3)),
                    8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        while (sb.in_command()) send_idle(1);
      end else begin
        send_idle($urandom_range(0, 2));
        run_command(CMD_START, 8'($urandom), 1'($urandom_range(0, 1)), 8'h00, 1'b0,
                    $urandom_range(0, 2) == 0);
        n_bytes = $urandom_range(1, 4);
        repeat (n_bytes) begin
          send_idle($urandom_range(0, 1));
          run_command($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, 8'($urandom),
                      1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 2) == 0);
        end
        run_command(CMD_STOP, 8'($urandom), 1'($urandom_range(0, 1)), 8'h00, 1'b0,
                    $urandom_range(0, 2) == 0);
      end
    end

    // Let the last predictions come back, then allow for stray beats.
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("i2c_master_byte_sequencer test passed");
    end else begin
      $display("i2c_master_byte_sequencer test failed");
    end
    $finish;
  end

endmodule
